### rtl/lcgp_pkg.sv
// Shared types and constants for the LRU cache block.
package lcgp_pkg;

    // Operation code carried on the request word
    typedef enum logic [0:0]
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // Capacity register
    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Position field in the cell control word; covers up to 256 cells
    localparam int POS_W = 8;

    // Sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    // Control word broadcast to every cell
    typedef struct packed
    {
        logic             upd;   // shift the row this cycle
        logic [POS_W-1:0] pos;   // last cell that takes its left neighbour
    } cell_ctrl_t;

endpackage

### rtl/lcgp_if.sv
// Request and response channel interfaces for the LRU cache block.
interface lcgp_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] write_value;

    modport source (output valid, cmd, key, write_value, input ready);
    modport sink   (input valid, cmd, key, write_value, output ready);
endinterface

interface lcgp_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

### rtl/lcgp_cell.sv
// One recency-ordered cell of the LRU row: holds an entry, compares it, shifts right.
module lcgp_cell
    import lcgp_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic                  left_valid,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  match
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  shift_en;

    // cells up to and including the boundary take their left neighbour
    assign shift_en = ctrl.upd && (POS_W'(INDEX) <= ctrl.pos);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (shift_en)
        begin
            valid_next = left_valid;
            key_next   = left_key;
            value_next = left_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign match = valid_reg && (key_reg == lookup_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

### rtl/lru_cache_get_put.sv
// A get or put is compared in the compare state; its result word is registered
// as the shift state through the recency-ordered cell row completes. A new
// request waits for the last to finish; a stalled result holds the shift state.
// Reset: valid marks, entry count and sequencer clear at once; capacity
// returns to 16. No clearing pass; a request is taken in the first cycle.
module lru_cache_get_put
    import lcgp_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    lcgp_req_if.sink         req,
    lcgp_rsp_if.source       rsp
);

    localparam int POS_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_BITS = ((CNT_BITS > CAP_W) ? CNT_BITS : CAP_W) + 1;

    // sequencer and item registers
    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    // lookup results
    logic                  hit_reg, hit_next;
    logic [POS_BITS-1:0]   hit_pos_reg, hit_pos_next;
    logic [VALUE_BITS-1:0] hit_value_reg, hit_value_next;

    // result word
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_hit_reg, rsp_hit_next;
    logic [VALUE_BITS-1:0] rsp_value_reg, rsp_value_next;

    // cell row
    logic                  cell_valid [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   cell_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;
    cell_ctrl_t            ctrl;
    logic [VALUE_BITS-1:0] new_value;

    logic                  req_fire;
    logic                  out_free;
    logic                  finish;
    logic                  is_put;
    logic                  evict;
    logic [CMP_BITS-1:0]   eff_cap;
    logic [POS_BITS-1:0]   pos_sel;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign finish    = (state_reg == ST_UPD) && out_free;
    assign req.ready = (state_reg == ST_IDLE) || finish;
    assign req_fire  = req.valid && req.ready;
    assign is_put    = (cmd_reg == CMD_PUT);

    // effective capacity: zero acts as one, clipped at the row length
    always_comb
    begin
        eff_cap = CMP_BITS'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = CMP_BITS'(1);
        end
        if (eff_cap > CMP_BITS'(MAX_ENTRIES))
        begin
            eff_cap = CMP_BITS'(MAX_ENTRIES);
        end
    end

    assign evict = CMP_BITS'(count_reg) >= eff_cap;

    // shift boundary: hit entry, last entry on eviction, or first free cell
    always_comb
    begin
        if (hit_reg)
        begin
            pos_sel = hit_pos_reg;
        end
        else if (evict)
        begin
            pos_sel = POS_BITS'(count_reg - 1'b1);
        end
        else
        begin
            pos_sel = POS_BITS'(count_reg);
        end
    end

    assign ctrl.upd  = finish && (hit_reg || is_put);
    assign ctrl.pos  = POS_W'(pos_sel);
    assign new_value = is_put ? wval_reg : hit_value_reg;

    // the row: cell 0 is most recent, each cell fed by its left neighbour
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic                  lv;
        logic [KEY_BITS-1:0]   lk;
        logic [VALUE_BITS-1:0] lval;

        if (i == 0)
        begin : g_head
            assign lv   = 1'b1;
            assign lk   = key_reg;
            assign lval = new_value;
        end
        else
        begin : g_body
            assign lv   = cell_valid[i-1];
            assign lk   = cell_key[i-1];
            assign lval = cell_value[i-1];
        end

        lcgp_cell #(
            .INDEX      (i),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .lookup_key (key_reg),
            .left_valid (lv),
            .left_key   (lk),
            .left_value (lval),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .match      (cell_match[i])
        );
    end

    // encode the (at most one) matching cell
    always_comb
    begin
        hit_next       = |cell_match;
        hit_pos_next   = '0;
        hit_value_next = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_pos_next   = hit_pos_next | POS_BITS'(i);
                hit_value_next = hit_value_next | cell_value[i];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (finish)
                begin
                    state_next = req_fire ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry count grows only on a put miss without eviction
    always_comb
    begin
        count_next = count_reg;
        if (finish && is_put && !hit_reg && !evict)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // result word
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_hit_next   = rsp_hit_reg;
        rsp_value_next = rsp_value_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
            rsp_hit_next   = hit_reg;
            rsp_value_next = (hit_reg && !is_put) ? hit_value_reg : '0;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg  <= cmd_t'(req.cmd);
            key_reg  <= req.key;
            wval_reg <= req.write_value;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg       <= hit_next;
            hit_pos_reg   <= hit_pos_next;
            hit_value_reg <= hit_value_next;
        end
        rsp_hit_reg   <= rsp_hit_next;
        rsp_value_reg <= rsp_value_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.read_value = rsp_value_reg;

endmodule

### rtl/lcgp_checker.sv
// Port-level checks for the LRU cache block, bound to the top level.
module lcgp_checker #(
    parameter int VALUE_BITS = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  rsp_hit,
    input logic [VALUE_BITS-1:0] rsp_read_value
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
        else $error("result word changed while stalled");

    // a miss never carries data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_read_value == '0)
        else $error("miss carries a non-zero read value");

    // one item in flight: no request taken in the compare cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken during lookup");

endmodule

bind lru_cache_get_put lcgp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lcgp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value)
);
